// File: sv/regression_tree_best_split_defines.svh
// assertion macros for the best split search block
`ifndef REGRESSION_TREE_BEST_SPLIT_DEFINES_SVH
`define REGRESSION_TREE_BEST_SPLIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define RTBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define RTBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/rtbs_pkg.sv
// shared types and constants for the best split search block
package rtbs_pkg;
  localparam int XW = 32;
  localparam int YW = 16;
  localparam int WW = 16;
  localparam int SW = 64;
  localparam int CW = 33;
  localparam int IW = 10;
  localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef enum logic [1:0] {
    REG_LOW   = 2'd0,
    REG_HIGH  = 2'd1,
    REG_USE_W = 2'd2,
    REG_FLOOR = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic clear_acc;
    logic rd_en;
    logic add_total;
    logic add_left;
    logic load_next;
    logic score_start;
    logic latch_result;
  } dp_cmd_t;

  typedef struct packed {
    logic tie;
    logic score_done;
  } dp_stat_t;
endpackage

// File: sv/rtbs_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
module rtbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/rtbs_divider.sv
// restoring divider for floor(m*m/d), squaring in 32 bit partial products; saturates to SAT_MAX, 0 when d is 0
module rtbs_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] mag,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);
  typedef enum logic [2:0] {D_IDLE, D_P0, D_P1, D_P2, D_CHK, D_RUN} dstate_t;
  dstate_t state;
  logic [31:0] a0, a1;
  logic [63:0] p00, p01, p11, d;
  logic [63:0] hi, lo, q;
  logic [6:0]  cnt;
  logic [64:0] shifted;
  logic [127:0] prod;

  assign prod = {p11, p00} + {31'd0, p01, 33'd0};
  assign shifted = {hi, lo[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            a0 <= mag[31:0];
            a1 <= mag[63:32];
            d  <= den;
            state <= D_P0;
          end
        end
        D_P0: begin
          p00 <= a0 * a0;
          state <= D_P1;
        end
        D_P1: begin
          p01 <= a0 * a1;
          state <= D_P2;
        end
        D_P2: begin
          p11 <= a1 * a1;
          state <= D_CHK;
        end
        D_CHK: begin
          hi <= prod[127:64];
          lo <= prod[63:0];
          q  <= '0;
          cnt <= '0;
          if (d == '0) begin
            quot <= '0;
            done <= 1'b1;
            state <= D_IDLE;
          end else if (prod[127:64] >= d) begin
            quot <= rtbs_pkg::SAT_MAX;
            done <= 1'b1;
            state <= D_IDLE;
          end else begin
            state <= D_RUN;
          end
        end
        D_RUN: begin
          lo <= {lo[62:0], 1'b0};
          if (shifted >= {1'b0, d}) begin
            hi <= 64'(shifted - {1'b0, d});
            q  <= {q[62:0], 1'b1};
          end else begin
            hi <= shifted[63:0];
            q  <= {q[62:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            state <= D_IDLE;
            done  <= 1'b1;
            quot  <= q[62] ? rtbs_pkg::SAT_MAX : {q[62:0], (shifted >= {1'b0, d})};
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end
endmodule

// File: sv/rtbs_datapath.sv
// datapath: stores, sums, scoring and best cut tracking
module rtbs_datapath #(
  parameter int MAX_OBS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_OBS)-1:0]      wr_addr,
  input  logic signed [rtbs_pkg::XW-1:0]  x_value,
  input  logic signed [rtbs_pkg::YW-1:0]  y_value,
  input  logic [rtbs_pkg::WW-1:0]         weight,
  input  logic [$clog2(MAX_OBS)-1:0]      rd_addr,
  input  logic                            use_w,
  input  logic signed [rtbs_pkg::SW-1:0]  score_floor,
  input  rtbs_pkg::dp_cmd_t               cmd,
  output rtbs_pkg::dp_stat_t              stat,
  output logic signed [rtbs_pkg::CW-1:0]  cut_res,
  output logic signed [rtbs_pkg::SW-1:0]  best_res,
  output logic                            found_res
);
  import rtbs_pkg::*;

  logic signed [XW-1:0] x_rd, x_cur, x_nxt;
  logic signed [YW-1:0] y_rd;
  logic [WW-1:0] w_rd;
  logic signed [SW-1:0] s_item, w_item, tot_s, tot_w, ls, lw;
  logic signed [SW-1:0] best;
  logic signed [CW-1:0] cut;
  logic found;
  logic score_done;
  logic [1:0] sstep;
  logic [SW-1:0] mag, den, t0;
  logic div_start, div_done;
  logic [SW-1:0] quot;
  logic signed [SW-1:0] rs, rw;
  logic [SW:0] sum;
  logic [SW-1:0] sc;

  rtbs_ram #(.WIDTH(XW), .DEPTH(MAX_OBS)) u_x (.clk, .we(wr_en), .waddr(wr_addr),
    .wdata(x_value), .raddr(rd_addr), .rdata(x_rd));
  rtbs_ram #(.WIDTH(YW), .DEPTH(MAX_OBS)) u_y (.clk, .we(wr_en), .waddr(wr_addr),
    .wdata(y_value), .raddr(rd_addr), .rdata(y_rd));
  rtbs_ram #(.WIDTH(WW), .DEPTH(MAX_OBS)) u_w (.clk, .we(wr_en), .waddr(wr_addr),
    .wdata(weight), .raddr(rd_addr), .rdata(w_rd));

  always_comb begin
    if (use_w) begin
      s_item = SW'(y_rd) * SW'($signed({1'b0, w_rd}));
      w_item = SW'({1'b0, w_rd});
    end else begin
      s_item = SW'(y_rd);
      w_item = SW'(1);
    end
  end

  assign rs = tot_s - ls;
  assign rw = tot_w - lw;
  assign stat.tie = (x_cur == x_nxt);
  assign stat.score_done = score_done;
  assign sum = {1'b0, t0} + {1'b0, quot};
  assign sc = (sum > {1'b0, SAT_MAX}) ? SAT_MAX : sum[SW-1:0];

  always_comb begin
    if (sstep == 2'd0) begin
      mag = ls[SW-1] ? 64'(-ls) : ls;
      den = lw[SW-1] ? '0 : lw;
    end else begin
      mag = rs[SW-1] ? 64'(-rs) : rs;
      den = rw[SW-1] ? '0 : rw;
    end
  end

  rtbs_divider u_div (.clk, .rst, .start(div_start), .mag, .den, .done(div_done),
    .quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      sstep <= '0;
      div_start <= 1'b0;
      score_done <= 1'b0;
      found <= 1'b0;
    end else begin
      div_start <= 1'b0;
      score_done <= 1'b0;
      if (cmd.clear_acc) begin
        tot_s <= '0; tot_w <= '0; ls <= '0; lw <= '0;
        best <= score_floor; cut <= '0; found <= 1'b0;
      end
      if (cmd.add_total) begin
        tot_s <= tot_s + s_item;
        tot_w <= tot_w + w_item;
      end
      if (cmd.add_left) begin
        ls <= ls + s_item;
        lw <= lw + w_item;
        x_cur <= x_rd;
      end
      if (cmd.load_next) begin
        x_nxt <= x_rd;
      end
      if (cmd.score_start) begin
        sstep <= 2'd0;
        div_start <= 1'b1;
      end
      if (div_done) begin
        if (sstep == 2'd0) begin
          t0 <= quot;
          sstep <= 2'd1;
          div_start <= 1'b1;
        end else begin
          score_done <= 1'b1;
          if ($signed(sc) > best) begin
            best <= $signed(sc);
            cut <= CW'(x_cur) + CW'(x_nxt);
            found <= 1'b1;
          end
        end
      end
      if (cmd.latch_result) begin
        cut_res <= cut;
        best_res <= best;
        found_res <= found;
      end
    end
  end
endmodule

// File: sv/rtbs_ctrl.sv
// controller: load, total pass and cut sweep sequencing
module rtbs_ctrl #(
  parameter int MAX_OBS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic                          in_last,
  input  logic [rtbs_pkg::IW-1:0]       low_index,
  input  logic [rtbs_pkg::IW-1:0]       high_index,
  input  rtbs_pkg::dp_stat_t            stat,
  output rtbs_pkg::dp_cmd_t             cmd,
  output logic                          wr_en,
  output logic [$clog2(MAX_OBS)-1:0]    wr_addr,
  output logic [$clog2(MAX_OBS)-1:0]    rd_addr,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_ready
);
  import rtbs_pkg::*;
  localparam int AW = $clog2(MAX_OBS);
  localparam int CNTW = AW + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_TOT_RD, S_TOT_ADD, S_INIT, S_LEFT_RD, S_LEFT_ADD,
    S_NXT_RD, S_NXT_LD, S_TIE, S_SCORE, S_WAIT, S_DONE, S_OUT
  } state_t;
  state_t state;
  logic [CNTW-1:0] cnt, k, pos, i, hi;
  logic [CNTW-1:0] lim;

  assign wr_en = in_fire && (cnt < CNTW'(MAX_OBS));
  assign wr_addr = cnt[AW-1:0];
  assign busy = (state != S_LOAD);
  assign lim = (CNTW'(high_index) < cnt - CNTW'(2)) ? CNTW'(high_index) : cnt - CNTW'(2);

  always_comb begin
    cmd = '0;
    rd_addr = k[AW-1:0];
    unique case (state)
      S_TOT_RD:   cmd.rd_en = 1'b1;
      S_TOT_ADD:  cmd.add_total = 1'b1;
      S_INIT:     cmd.clear_acc = 1'b1;
      S_LEFT_ADD: cmd.add_left = 1'b1;
      S_NXT_LD:   cmd.load_next = 1'b1;
      S_SCORE:    cmd.score_start = 1'b1;
      S_DONE:     cmd.latch_result = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt <= '0;
      out_valid <= 1'b0;
      k <= '0; pos <= '0; i <= '0; hi <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (cnt < CNTW'(MAX_OBS)) cnt <= cnt + CNTW'(1);
            if (in_last) state <= S_INIT;
          end
        end
        S_INIT: begin
          k <= '0;
          state <= (cnt == '0) ? S_DONE : S_TOT_RD;
        end
        S_TOT_RD: state <= S_TOT_ADD;
        S_TOT_ADD: begin
          if (k + CNTW'(1) == cnt) begin
            i <= CNTW'(low_index);
            pos <= '0;
            k <= '0;
            hi <= lim;
            if (cnt < CNTW'(2) || CNTW'(low_index) > lim) state <= S_DONE;
            else state <= S_LEFT_RD;
          end else begin
            k <= k + CNTW'(1);
            state <= S_TOT_RD;
          end
        end
        S_LEFT_RD: begin
          k <= pos;
          state <= S_LEFT_ADD;
        end
        S_LEFT_ADD: begin
          if (pos == i) begin
            pos <= pos + CNTW'(1);
            k <= i + CNTW'(1);
            state <= S_NXT_RD;
          end else begin
            pos <= pos + CNTW'(1);
            k <= pos + CNTW'(1);
            state <= S_LEFT_RD;
          end
        end
        S_NXT_RD: state <= S_NXT_LD;
        S_NXT_LD: state <= S_TIE;
        S_TIE: begin
          if (stat.tie) begin
            i <= i + CNTW'(1);
            if (i + CNTW'(2) >= cnt) state <= S_DONE;
            else state <= S_LEFT_RD;
          end else begin
            state <= S_SCORE;
          end
        end
        S_SCORE: state <= S_WAIT;
        S_WAIT: begin
          if (stat.score_done) begin
            if (i + CNTW'(1) > hi) state <= S_DONE;
            else begin
              i <= i + CNTW'(1);
              state <= S_LEFT_RD;
            end
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            cnt <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// File: sv/regression_tree_best_split.sv
// top level of the regression tree best split search
//  channel | dir | handshake
//  in      | in  | in_valid / in_ready: x_value y_value weight last
//  out     | out | out_valid / out_ready: cut_doubled best_score found
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// loads one item per cycle into three block rams
// after the last item: a totals pass reads and adds each item, then for each cut the left sums
// are extended item by item, the next x is read, and a score takes two 64 step divisions
// rst is synchronous; no item is taken while the sweep runs or a result waits
`include "regression_tree_best_split_defines.svh"
module regression_tree_best_split #(
  parameter int MAX_OBS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             x_value,
  input  logic signed [15:0]             y_value,
  input  logic [15:0]                    weight,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [32:0]             cut_doubled,
  output logic signed [63:0]             best_score,
  output logic                           found,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [63:0]                    cfg_data
);
  import rtbs_pkg::*;
  localparam int AW = $clog2(MAX_OBS);

  logic [IW-1:0] low_index, high_index;
  logic use_weight;
  logic signed [SW-1:0] score_floor;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic wr_en, busy, in_fire;
  logic [AW-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_index <= '0;
      high_index <= IW'(1022);
      use_weight <= 1'b0;
      score_floor <= -64'sd1;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_LOW:   low_index <= cfg_data[IW-1:0];
        REG_HIGH:  high_index <= cfg_data[IW-1:0];
        REG_USE_W: use_weight <= cfg_data[0];
        REG_FLOOR: score_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;

  rtbs_ctrl #(.MAX_OBS(MAX_OBS)) u_ctrl (.clk, .rst, .in_fire, .in_last(last),
    .low_index, .high_index, .stat, .cmd, .wr_en, .wr_addr, .rd_addr, .busy,
    .out_valid, .out_ready);

  rtbs_datapath #(.MAX_OBS(MAX_OBS)) u_dp (.clk, .rst, .wr_en, .wr_addr, .x_value,
    .y_value, .weight, .rd_addr, .use_w(use_weight), .score_floor, .cmd, .stat,
    .cut_res(cut_doubled), .best_res(best_score), .found_res(found));

  `RTBS_ASSERT_IMP(a_no_in_while_out, out_valid, !in_ready, "item taken while result waits")
  `RTBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(best_score),
    "result dropped")
  `RTBS_ASSERT_IMP(a_found_cut, out_valid && !found, cut_doubled == '0, "cut without find")
endmodule
